FILE: rtl/psfp_pkg.sv
// shared constants and types of the particle sensor frame parser
`default_nettype none
package psfp_pkg;

  localparam logic [7:0] START_BYTE  = 8'h42;
  localparam int         FRAME_BYTES = 32;
  localparam int         SUM_BYTES   = 30;
  localparam int         EMIT_WORDS  = 13;
  localparam int         FRAME_BUFS  = 2;

  localparam int BANK_W = $clog2(FRAME_BUFS);
  localparam int IDX_W  = $clog2(EMIT_WORDS);
  localparam int POS_W  = $clog2(FRAME_BYTES);
  localparam int CNT_W  = $clog2(FRAME_BUFS + 1);

  localparam logic [POS_W-1:0]  POS_FIRST_WORD = POS_W'(3);
  localparam logic [POS_W-1:0]  POS_LAST_WORD  = POS_W'(3 + 2 * (EMIT_WORDS - 1));
  localparam logic [POS_W-1:0]  POS_SUM_END    = POS_W'(SUM_BYTES);
  localparam logic [POS_W-1:0]  POS_FINAL      = POS_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST       = IDX_W'(EMIT_WORDS - 1);
  localparam logic [BANK_W-1:0] BANK_LAST      = BANK_W'(FRAME_BUFS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL       = CNT_W'(FRAME_BUFS);

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       data;
  } wr_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [BANK_W-1:0] wr_bank;
    logic [BANK_W-1:0] rd_bank;
    logic              head_ok;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/particle_sensor_frame_parser.sv
// top level of the particle sensor frame parser
//
//   channel | direction | ports                                   | handshake
//   in      | input     | in_rx_byte                              | in_valid / in_stall
//   out     | output    | out_word_index, out_word_value,         | out_valid / out_stall
//           |           | out_checksum_ok, out_last               |
//
// one byte per cycle is taken while in_stall is low; a 32-byte frame yields 13 words,
// one per cycle while out_stall is low, once the frame reaches the head of the queue
// frame words sit in two buffer banks, so in_stall rises only while two
// finished frames still wait to be drained by the output side
// out_stall holds the output register and, through the frame queue, the input
// synchronous active-low reset returns the parser to hunting with no frames queued
`default_nettype none
module particle_sensor_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_word_index,
  output logic [15:0]      out_word_value,
  output logic             out_checksum_ok,
  output logic             out_last
);
  import psfp_pkg::*;

  wr_t     wr;
  q_stat_t q_stat;
  logic    push;
  logic    push_ok;
  logic    pop;

  psfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .wr         (wr),
    .push       (push),
    .push_ok    (push_ok)
  );

  psfp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ok (push_ok),
    .pop     (pop),
    .q_stat  (q_stat)
  );

  psfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr              (wr),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_checksum_ok (out_checksum_ok),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: rtl/psfp_front.sv
// byte parser: frame sync, checksum sum and word assembly
`default_nettype none
module psfp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  input  wire psfp_pkg::q_stat_t q_stat,
  output psfp_pkg::wr_t         wr,
  output logic                  push,
  output logic                  push_ok
);
  import psfp_pkg::*;

  logic             hunting_r, hunting_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic             accept;
  logic [POS_W-1:0] pos_off;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign pos_off  = pos_r - POS_FIRST_WORD;

  always_comb begin
    hunting_nxt = hunting_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    hold_nxt    = hold_r;
    wr.en       = 1'b0;
    wr.bank     = q_stat.wr_bank;
    wr.idx      = pos_off[IDX_W:1];
    wr.data     = {hold_r, in_rx_byte};
    push        = 1'b0;
    push_ok     = ({hold_r, in_rx_byte} == sum_r);
    if (accept) begin
      if (hunting_r) begin
        if (in_rx_byte == START_BYTE) begin
          hunting_nxt = 1'b0;
          sum_nxt     = {8'h00, START_BYTE};
          pos_nxt     = POS_W'(1);
        end
      end else begin
        if (pos_r < POS_SUM_END) begin
          sum_nxt = sum_r + {8'h00, in_rx_byte};
        end
        if (!pos_r[0]) begin
          hold_nxt = in_rx_byte;
        end else if (pos_r >= POS_FIRST_WORD && pos_r <= POS_LAST_WORD) begin
          wr.en = 1'b1;
        end
        if (pos_r == POS_FINAL) begin
          push        = 1'b1;
          hunting_nxt = 1'b1;
          pos_nxt     = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r <= 1'b1;
      pos_r     <= '0;
      sum_r     <= '0;
      hold_r    <= '0;
    end else begin
      hunting_r <= hunting_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      hold_r    <= hold_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/psfp_queue.sv
// queue of finished frames: buffer bank order and checksum result
`default_nettype none
module psfp_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        push_ok,
  input  wire logic        pop,
  output psfp_pkg::q_stat_t q_stat
);
  import psfp_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BANK_W-1:0] wr_ptr_r, rd_ptr_r;
  logic              ok_r [FRAME_BUFS];

  assign q_stat.full    = (cnt_r == CNT_FULL);
  assign q_stat.empty   = (cnt_r == '0);
  assign q_stat.wr_bank = wr_ptr_r;
  assign q_stat.rd_bank = rd_ptr_r;
  assign q_stat.head_ok = ok_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ok_r[wr_ptr_r] <= push_ok;
    end
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == BANK_LAST) ? '0 : wr_ptr_r + BANK_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == BANK_LAST) ? '0 : rd_ptr_r + BANK_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/psfp_back.sv
// frame word buffers and word emitter with output register
`default_nettype none
module psfp_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire psfp_pkg::wr_t wr,
  input  wire psfp_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [3:0]        out_word_index,
  output logic [15:0]       out_word_value,
  output logic              out_checksum_ok,
  output logic              out_last
);
  import psfp_pkg::*;

  logic [15:0]      buf_r [FRAME_BUFS][EMIT_WORDS];
  logic [IDX_W-1:0] k_r;
  logic             out_valid_r;
  logic [3:0]       index_r;
  logic [15:0]      value_r;
  logic             ok_r;
  logic             last_r;
  logic             load;

  assign load = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop  = load && (k_r == IDX_LAST);

  assign out_valid       = out_valid_r;
  assign out_word_index  = index_r;
  assign out_word_value  = value_r;
  assign out_checksum_ok = ok_r;
  assign out_last        = last_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      buf_r[wr.bank][wr.idx] <= wr.data;
    end
    if (load) begin
      index_r <= 4'(k_r);
      value_r <= buf_r[q_stat.rd_bank][k_r];
      ok_r    <= q_stat.head_ok;
      last_r  <= (k_r == IDX_LAST);
    end
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        k_r         <= (k_r == IDX_LAST) ? '0 : k_r + IDX_W'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/psfp_checker.sv
// port-level assertions for the particle sensor frame parser and their bind
`default_nettype none
module psfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_word_index,
  input wire logic [15:0] out_word_value,
  input wire logic        out_checksum_ok,
  input wire logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index)
      && $stable(out_word_value) && $stable(out_checksum_ok) && $stable(out_last))
    else $error("stalled output item changed");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_word_index == 4'd12)))
    else $error("last flag does not match final word index");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_index <= 4'd12)
    else $error("word index out of range");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid
      && (out_word_index == $past(out_word_index) + 4'd1)
      && (out_checksum_ok == $past(out_checksum_ok)))
    else $error("word run broken or checksum flag changed within a frame");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_word_index  (out_word_index),
  .out_word_value  (out_word_value),
  .out_checksum_ok (out_checksum_ok),
  .out_last        (out_last)
);
`default_nettype wire

FILE: sim/psfp_frame_checker.sv
`timescale 1ns / 100ps
// frame word predictor and result checker for the particle sensor frame parser
module psfp_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_word_index,
  input  wire logic [15:0] out_word_value,
  input  wire logic        out_checksum_ok,
  input  wire logic        out_last,
  output int               n_errors,
  output int               n_pending
);
  import psfp_pkg::*;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] value;
    logic        ok;
    logic        last;
  } frame_word_t;

  frame_word_t word_q[$];
  int          err_count;

  logic        seeking;
  logic [4:0]  frame_pos;
  logic [15:0] byte_sum;
  logic [7:0]  hi_byte;
  logic [15:0] word_mem [14];

  task automatic take_byte(input logic [7:0] b);
    logic [15:0] check;
    frame_word_t w;
    if (seeking) begin
      if (b == START_BYTE) begin
        seeking   = 1'b0;
        byte_sum  = 16'(START_BYTE);
        frame_pos = 5'd1;
      end
    end else begin
      if (frame_pos < SUM_BYTES) begin
        byte_sum = byte_sum + 16'(b);
      end
      if (frame_pos >= 2 && !frame_pos[0]) begin
        hi_byte = b;
      end else if (frame_pos >= 3 && frame_pos < FRAME_BYTES - 1) begin
        word_mem[(frame_pos - 3) >> 1] = {hi_byte, b};
      end
      if (frame_pos == FRAME_BYTES - 1) begin
        check = {hi_byte, b};
        for (int k = 0; k < EMIT_WORDS; k++) begin
          w.idx   = 4'(k);
          w.value = word_mem[k];
          w.ok    = (check == byte_sum);
          w.last  = (k == EMIT_WORDS - 1);
          word_q.push_back(w);
        end
        seeking   = 1'b1;
        frame_pos = 5'd0;
      end else begin
        frame_pos = frame_pos + 5'd1;
      end
    end
  endtask

  task automatic report(input string field, input int expd, input int act);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expd, act);
  endtask

  task automatic check_word();
    frame_word_t w;
    if (word_q.size() == 0) begin
      err_count++;
      $display("%0t: unexpected item, expected none, got index %0d value %h",
               $time, out_word_index, out_word_value);
    end else begin
      w = word_q.pop_front();
      if (out_word_index !== w.idx) report("word_index", w.idx, out_word_index);
      if (out_word_value !== w.value) report("word_value", w.value, out_word_value);
      if (out_checksum_ok !== w.ok) report("checksum_ok", w.ok, out_checksum_ok);
      if (out_last !== w.last) report("last", w.last, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      word_q.delete();
      err_count = 0;
      seeking   = 1'b1;
      frame_pos = 5'd0;
      byte_sum  = 16'd0;
      hi_byte   = 8'd0;
    end else begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) take_byte(in_rx_byte);
    end
    n_errors  <= err_count;
    n_pending <= word_q.size();
  end

endmodule

FILE: sim/tb_particle_sensor_frame_parser.sv
`timescale 1ns / 100ps
// testbench top: byte stimulus, output stall and verdict for the frame parser
module tb_particle_sensor_frame_parser;
  import psfp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  out_word_index;
  logic [15:0] out_word_value;
  logic        out_checksum_ok;
  logic        out_last;

  int          n_errors;
  int          n_pending;
  int          cycle_count = 0;
  int          stall_left  = 0;
  int          stall_draw;
  logic        in_quiet    = 1'b0;
  logic        out_quiet   = 1'b0;
  logic [7:0]  frame_buf [FRAME_BYTES];

  always #10 clk = ~clk;

  particle_sensor_frame_parser i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_checksum_ok (out_checksum_ok),
    .out_last        (out_last)
  );

  psfp_frame_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_checksum_ok (out_checksum_ok),
    .out_last        (out_last),
    .n_errors        (n_errors),
    .n_pending       (n_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // output side stall: a drawn, possibly zero hold after each item (none while quiet), short blips while idle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      out_quiet  <= 1'b0;
    end else if (out_stall) begin
      if (stall_left == 0) out_stall <= 1'b0;
      else stall_left <= stall_left - 1;
    end else if (out_valid) begin
      stall_draw = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall_draw > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_draw - 1;
      end
      if (out_last) out_quiet <= ($urandom_range(0, 2) == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // fills in the checksum word, optionally corrupted, then sends the first keep bytes
  task automatic seal_and_send(input logic bad, input int keep);
    logic [15:0] sum;
    sum = 16'd0;
    for (int i = 0; i < SUM_BYTES; i++) sum = sum + 16'(frame_buf[i]);
    if (bad) sum = sum ^ 16'($urandom_range(1, 65535));
    frame_buf[SUM_BYTES]     = sum[15:8];
    frame_buf[SUM_BYTES + 1] = sum[7:0];
    for (int i = 0; i < keep; i++) send_byte(frame_buf[i]);
  endtask

  initial begin
    int          data_bytes;
    int          n_frames;
    int          keep;
    logic        bad;
    logic [7:0]  noise;

    data_bytes = 0;
    n_frames   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // non-start bytes while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'h43);

    // unchecked second sync byte, zero and full words, start byte as data
    frame_buf[0] = START_BYTE;
    frame_buf[1] = 8'h00;
    for (int i = 2; i < SUM_BYTES; i++) frame_buf[i] = (i % 4 < 2) ? 8'hFF : 8'h00;
    frame_buf[3] = 8'h1C;
    frame_buf[8] = START_BYTE;
    frame_buf[9] = START_BYTE;
    seal_and_send(1'b0, FRAME_BYTES);

    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);

    while (data_bytes < 120) begin
      in_quiet = ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(0, 3)) begin
        noise = 8'($urandom);
        if (noise == START_BYTE) noise = 8'h00;
        send_byte(noise);
      end
      frame_buf[0] = START_BYTE;
      frame_buf[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h4D;
      for (int i = 2; i < SUM_BYTES; i++) begin
        case ($urandom_range(0, 7))
          0:       frame_buf[i] = 8'h00;
          1:       frame_buf[i] = 8'hFF;
          2:       frame_buf[i] = START_BYTE;
          default: frame_buf[i] = 8'($urandom);
        endcase
      end
      bad  = ($urandom_range(0, 3) == 0) || (n_frames == 1);
      keep = ($urandom_range(0, 7) == 0) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
      seal_and_send(bad, keep);
      data_bytes += keep;
      n_frames++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
